// File: design/netc_pkg.sv
// Shared types and codes for the named entry table.
package netc_pkg;

  localparam int KEY_W   = 160;
  localparam int SIZE_W  = 32;
  localparam int ENUM_W  = 7;

  typedef enum logic [1:0] {
    FN_CREATE = 2'd0,
    FN_DELETE = 2'd1,
    FN_LIST   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_CREATED   = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_LISTED    = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [63:0]        key_bytes_0_7;
    logic [63:0]        key_bytes_8_15;
    logic [31:0]        key_bytes_16_19;
    logic signed [31:0] size_kb;
  } netc_in_t;

  typedef struct packed {
    status_t            status;
    logic [ENUM_W-1:0]  entry_number;
    logic [63:0]        out_bytes_0_7;
    logic [63:0]        out_bytes_8_15;
    logic [31:0]        out_bytes_16_19;
    logic signed [31:0] out_size_kb;
    logic               last;
  } netc_out_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
  } netc_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_APPEND,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_LIST_RD,
    S_LIST_OUT,
    S_RESPOND
  } netc_state_t;

  typedef struct packed {
    logic    load_req;
    logic    idx_inc;
    logic    rd_next;
    logic    wr_en;
    logic    wr_append;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
    logic    emit_row;
    logic    emit_last;
    status_t code;
  } netc_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       count_zero;
    logic       count_full;
    logic       match;
    logic       idx_last;
    logic       idx_next_last;
  } netc_stat_t;

endpackage

// File: design/netc_datapath.sv
// Table memory, request and index registers, and result register.
module netc_datapath import netc_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  netc_in_t   in_data,
  input  netc_cmd_t  cmd,
  output netc_stat_t stat,
  output netc_out_t  out_data,
  output logic       out_valid
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  netc_entry_t mem [TABLE_DEPTH];

  netc_in_t         req_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  netc_entry_t      rdata_r;
  netc_out_t        out_r, out_nxt;
  logic             out_valid_r;
  logic [KEY_W-1:0] req_key;
  logic [CW-1:0]    idx_plus1;
  logic [AW-1:0]    rd_addr, wr_addr;
  netc_entry_t      wr_data;

  assign req_key   = {req_r.key_bytes_16_19, req_r.key_bytes_8_15, req_r.key_bytes_0_7};
  assign idx_plus1 = idx_r + 1'b1;
  assign rd_addr   = cmd.rd_next ? idx_plus1[AW-1:0] : idx_r[AW-1:0];
  assign wr_addr   = cmd.wr_append ? count_r[AW-1:0] : idx_r[AW-1:0];

  always_comb begin
    if (cmd.wr_append) begin
      wr_data.key  = req_key;
      wr_data.size = req_r.size_kb;
    end else begin
      wr_data = rdata_r;
    end
  end

  // single write port, single registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - 1'b1;
    end
    idx_nxt = idx_r;
    if (cmd.load_req) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_plus1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_data;
    end
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    out_nxt.last = cmd.emit_last;
    if (cmd.emit_row) begin
      out_nxt.status          = ST_LISTED;
      out_nxt.entry_number    = ENUM_W'(idx_r) + 1'b1;
      out_nxt.out_bytes_0_7   = rdata_r.key[63:0];
      out_nxt.out_bytes_8_15  = rdata_r.key[127:64];
      out_nxt.out_bytes_16_19 = rdata_r.key[159:128];
      out_nxt.out_size_kb     = rdata_r.size;
    end else begin
      out_nxt.status          = cmd.code;
      out_nxt.entry_number    = '0;
      out_nxt.out_size_kb     = '0;
      if (cmd.code == ST_EMPTY) begin
        out_nxt.out_bytes_0_7   = '0;
        out_nxt.out_bytes_8_15  = '0;
        out_nxt.out_bytes_16_19 = '0;
      end else begin
        out_nxt.out_bytes_0_7   = req_r.key_bytes_0_7;
        out_nxt.out_bytes_8_15  = req_r.key_bytes_8_15;
        out_nxt.out_bytes_16_19 = req_r.key_bytes_16_19;
      end
    end
  end

  assign stat.func          = req_r.func;
  assign stat.count_zero    = (count_r == '0);
  assign stat.count_full    = (count_r == CW'(TABLE_DEPTH));
  assign stat.match         = (rdata_r.key == req_key);
  assign stat.idx_last      = (idx_plus1 == count_r);
  assign stat.idx_next_last = (({1'b0, idx_r} + 2'd2) == {1'b0, count_r});

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_no_inc_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !stat.count_full)
    else $error("append into a full table");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.last |-> out_r.status == ST_LISTED)
    else $error("non-final result that is not a listed entry");
`endif

endmodule

// File: design/netc_ctrl.sv
// Sequencer for create, delete and list requests.
module netc_ctrl import netc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  netc_stat_t stat,
  output netc_cmd_t  cmd,
  output logic       busy
);

  netc_state_t state_r, state_nxt;
  status_t     code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_CREATED;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.func)
          FN_CREATE: begin
            if (stat.count_full) begin
              code_nxt  = ST_FULL;
              state_nxt = S_RESPOND;
            end else if (stat.count_zero) begin
              state_nxt = S_APPEND;
            end else begin
              state_nxt = S_SRCH_RD;
            end
          end
          FN_DELETE: begin
            if (stat.count_zero) begin
              code_nxt  = ST_NOT_FOUND;
              state_nxt = S_RESPOND;
            end else begin
              state_nxt = S_SRCH_RD;
            end
          end
          FN_LIST: begin
            if (stat.count_zero) begin
              code_nxt  = ST_EMPTY;
              state_nxt = S_RESPOND;
            end else begin
              state_nxt = S_LIST_RD;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SRCH_RD: state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (stat.func == FN_CREATE) begin
          if (stat.match) begin
            code_nxt  = ST_DUPLICATE;
            state_nxt = S_RESPOND;
          end else if (stat.idx_last) begin
            state_nxt = S_APPEND;
          end else begin
            state_nxt = S_SRCH_RD;
          end
        end else begin
          if (stat.match) begin
            code_nxt  = ST_DELETED;
            state_nxt = stat.idx_last ? S_RESPOND : S_SHIFT_RD;
          end else if (stat.idx_last) begin
            code_nxt  = ST_NOT_FOUND;
            state_nxt = S_RESPOND;
          end else begin
            state_nxt = S_SRCH_RD;
          end
        end
      end
      S_APPEND:   state_nxt = S_IDLE;
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = stat.idx_next_last ? S_RESPOND : S_SHIFT_RD;
      S_LIST_RD:  state_nxt = S_LIST_OUT;
      S_LIST_OUT: state_nxt = stat.idx_last ? S_IDLE : S_LIST_RD;
      S_RESPOND:  state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.code     = code_r;
    case (state_r)
      S_IDLE: cmd.load_req = start;
      S_SRCH_CMP: begin
        if (!stat.match && !stat.idx_last) begin
          cmd.idx_inc = 1'b1;
        end
        // match on the final entry: nothing to move down
        if (stat.func == FN_DELETE && stat.match && stat.idx_last) begin
          cmd.cnt_dec = 1'b1;
        end
      end
      S_APPEND: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_append = 1'b1;
        cmd.cnt_inc   = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_last = 1'b1;
        cmd.code      = ST_CREATED;
      end
      S_SHIFT_RD: cmd.rd_next = 1'b1;
      S_SHIFT_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_inc = 1'b1;
        cmd.cnt_dec = stat.idx_next_last;
      end
      S_LIST_OUT: begin
        cmd.emit      = 1'b1;
        cmd.emit_row  = 1'b1;
        cmd.emit_last = stat.idx_last;
        cmd.idx_inc   = !stat.idx_last;
      end
      S_RESPOND: begin
        cmd.emit      = 1'b1;
        cmd.emit_last = 1'b1;
      end
      default: cmd.code = code_r;
    endcase
  end

  assign busy = (state_r != S_IDLE);

`ifndef SYNTHESIS
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> state_r == S_DECODE)
    else $error("accepted request not decoded");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_APPEND |-> !stat.count_full)
    else $error("append state reached with full table");
`endif

endmodule

// File: design/named_entry_table_with_compaction_core.sv
// Top level of the ordered named entry table with delete compaction.
//
// Usage: present a request on in_data and raise start; it is taken at a
// clock edge where start is high and busy is low. func selects create,
// delete or list. Results come out on out_data, each for one cycle with
// out_valid high; out_data.last marks the final result of a request.
// The receiver cannot hold results off, and none is needed: the table
// never emits faster than one result per cycle.
// Steps, n = entries in the table, one memory port walks the entries:
//   create full / list empty / delete on empty: decode, then respond.
//   create: read and compare per entry searched, then append.
//   delete: read, compare per entry searched; read, write per entry moved.
//   list: per entry a read, then its result is shown; n results.
// Busy drops in the cycle the last result is shown. Reset empties the
// table at once (the entry count clears); entry storage is not cleared.
// A request with the unused func code produces no result.
module named_entry_table_with_compaction_core import netc_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  netc_in_t  in_data,
  output netc_out_t out_data,
  output logic      out_valid
);

  netc_cmd_t  cmd;
  netc_stat_t stat;

  netc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  netc_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data),
    .out_valid (out_valid)
  );

endmodule

// File: test/named_entry_table_with_compaction_core_tb.sv
// Self-checking testbench for the named entry table with delete compaction.
module named_entry_table_with_compaction_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import netc_pkg::*;

  localparam int DEPTH = 64;
  localparam int POOL_SIZE = 48;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam logic signed [31:0] SIZE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] SIZE_MAX = 32'sh7fff_ffff;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  netc_in_t  in_data;
  netc_out_t out_data;
  logic      out_valid;

  // shadow copy of the directory
  logic [159:0]       tbl_key[DEPTH];
  logic signed [31:0] tbl_size[DEPTH];
  int                 tbl_count;

  netc_out_t    pending_rows[$];
  logic [159:0] name_pool[POOL_SIZE];
  int           sender_idle_pct;
  int           err_count;

  named_entry_table_with_compaction_core #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_data (out_data),
    .out_valid(out_valid)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("named_entry_table_with_compaction_core_tb: FAIL");
    $finish;
  end

  function automatic int find_entry(logic [159:0] k);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] == k) return i;
    end
    return -1;
  endfunction

  // Expected rows for one accepted request; updates the shadow table.
  function automatic void predict_rows(netc_in_t r);
    netc_out_t    row;
    logic [159:0] k;
    int           hit;
    k = {r.key_bytes_16_19, r.key_bytes_8_15, r.key_bytes_0_7};
    row = '0;
    row.out_bytes_0_7 = r.key_bytes_0_7;
    row.out_bytes_8_15 = r.key_bytes_8_15;
    row.out_bytes_16_19 = r.key_bytes_16_19;
    row.last = 1'b1;
    case (r.func)
      FN_CREATE: begin
        // full wins over duplicate
        if (tbl_count >= DEPTH) begin
          row.status = ST_FULL;
        end else if (find_entry(k) >= 0) begin
          row.status = ST_DUPLICATE;
        end else begin
          tbl_key[tbl_count] = k;
          tbl_size[tbl_count] = r.size_kb;
          tbl_count++;
          row.status = ST_CREATED;
        end
        pending_rows.push_back(row);
      end
      FN_DELETE: begin
        hit = find_entry(k);
        if (hit >= 0) begin
          for (int j = hit; j + 1 < tbl_count; j++) begin
            tbl_key[j] = tbl_key[j + 1];
            tbl_size[j] = tbl_size[j + 1];
          end
          tbl_count--;
          row.status = ST_DELETED;
        end else begin
          row.status = ST_NOT_FOUND;
        end
        pending_rows.push_back(row);
      end
      FN_LIST: begin
        if (tbl_count == 0) begin
          row = '0;
          row.status = ST_EMPTY;
          row.last = 1'b1;
          pending_rows.push_back(row);
        end else begin
          for (int i = 0; i < tbl_count; i++) begin
            row.status = ST_LISTED;
            row.entry_number = 7'(i + 1);
            row.out_bytes_0_7 = tbl_key[i][63:0];
            row.out_bytes_8_15 = tbl_key[i][127:64];
            row.out_bytes_16_19 = tbl_key[i][159:128];
            row.out_size_kb = tbl_size[i];
            row.last = (i + 1 == tbl_count);
            pending_rows.push_back(row);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic netc_in_t mk_req(logic [1:0] fn, logic [159:0] k,
                                      logic signed [31:0] sz);
    netc_in_t r;
    r.func = fn;
    r.key_bytes_0_7 = k[63:0];
    r.key_bytes_8_15 = k[127:64];
    r.key_bytes_16_19 = k[159:128];
    r.size_kb = sz;
    return r;
  endfunction

  // Nonzero bytes up to len, zero padding after.
  function automatic logic [159:0] make_name(int len);
    logic [159:0] k;
    k = '0;
    for (int i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(255, 1));
    return k;
  endfunction

  function automatic logic signed [31:0] rand_size();
    int p;
    p = $urandom_range(99);
    if (p < 4) return SIZE_MIN;
    if (p < 8) return SIZE_MAX;
    if (p < 10) return '0;
    return $urandom();
  endfunction

  // Caller sits at a rising edge; returns at the edge that ends the transfer
  // or after the following idle gap.
  task automatic send_req(netc_in_t r);
    int gap;
    gap = 0;
    in_data <= r;
    start <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_rows(r);
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    netc_out_t e;
    if (rst_n && out_valid) begin
      if (pending_rows.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t: unexpected result status=%0d num=%0d last=%0b", $realtime,
                   out_data.status, out_data.entry_number, out_data.last);
      end else begin
        e = pending_rows.pop_front();
        if (out_data.status !== e.status || out_data.entry_number !== e.entry_number ||
            out_data.out_bytes_0_7 !== e.out_bytes_0_7 ||
            out_data.out_bytes_8_15 !== e.out_bytes_8_15 ||
            out_data.out_bytes_16_19 !== e.out_bytes_16_19 ||
            out_data.out_size_kb !== e.out_size_kb || out_data.last !== e.last) begin
          err_count++;
          if (err_count <= 10) begin
            $display("%0t: mismatch exp st=%0d n=%0d key=%h_%h_%h sz=%0d last=%0b",
                     $realtime, e.status, e.entry_number, e.out_bytes_16_19,
                     e.out_bytes_8_15, e.out_bytes_0_7, e.out_size_kb, e.last);
            $display("%0t:          got st=%0d n=%0d key=%h_%h_%h sz=%0d last=%0b",
                     $realtime, out_data.status, out_data.entry_number,
                     out_data.out_bytes_16_19, out_data.out_bytes_8_15,
                     out_data.out_bytes_0_7, out_data.out_size_kb, out_data.last);
          end
        end
      end
    end
  end

  task automatic test_empty_table();
    send_req(mk_req(FN_LIST, make_name(20), SIZE_MAX));
    send_req(mk_req(FN_DELETE, '0, '0));
    send_req(mk_req(FN_DELETE, make_name(7), '0));
  endtask

  task automatic test_basic_ops();
    logic [159:0] ones;
    logic [159:0] short_name;
    ones = '1;
    short_name = make_name(1);
    send_req(mk_req(FN_CREATE, '0, SIZE_MIN));
    send_req(mk_req(FN_CREATE, ones, SIZE_MAX));
    send_req(mk_req(FN_CREATE, ones, 32'sd5));
    send_req(mk_req(FN_CREATE, short_name, '0));
    send_req(mk_req(FN_LIST, '0, '0));
    // middle delete closes the gap
    send_req(mk_req(FN_DELETE, ones, '0));
    send_req(mk_req(FN_LIST, ones, SIZE_MIN));
    send_req(mk_req(FN_DELETE, ones, '0));
    send_req(mk_req(FN_UNUSED, ones, SIZE_MAX));
    send_req(mk_req(FN_UNUSED, '0, '0));
    send_req(mk_req(FN_LIST, '0, '0));
    send_req(mk_req(FN_DELETE, '0, '0));
    send_req(mk_req(FN_DELETE, short_name, '0));
    send_req(mk_req(FN_LIST, '0, '0));
  endtask

  task automatic test_fill_and_drain();
    int n_del;
    while (tbl_count < DEPTH)
      send_req(mk_req(FN_CREATE, make_name($urandom_range(20, 1)), rand_size()));
    send_req(mk_req(FN_CREATE, make_name(20), rand_size()));
    // full and duplicate at once
    send_req(mk_req(FN_CREATE, tbl_key[5], rand_size()));
    send_req(mk_req(FN_LIST, '0, '0));
    send_req(mk_req(FN_DELETE, tbl_key[DEPTH - 1], '0));
    send_req(mk_req(FN_DELETE, tbl_key[0], '0));
    send_req(mk_req(FN_CREATE, tbl_key[30], rand_size()));
    send_req(mk_req(FN_LIST, '0, '0));
    n_del = 0;
    while (tbl_count > 0) begin
      send_req(mk_req(FN_DELETE, tbl_key[$urandom_range(tbl_count - 1)], '0));
      n_del++;
      if (n_del % 16 == 0) send_req(mk_req(FN_LIST, '0, '0));
    end
    send_req(mk_req(FN_LIST, '0, '0));
  endtask

  function automatic logic [159:0] pick_key();
    int p;
    p = $urandom_range(99);
    if (p < 65) return name_pool[$urandom_range(POOL_SIZE - 1)];
    if (p < 80 && tbl_count > 0) return tbl_key[$urandom_range(tbl_count - 1)];
    if (p < 95) return make_name($urandom_range(20));
    return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // first half grows the table, second half shrinks it
  task automatic test_random_traffic(int n_items, int idle_pct);
    int sent;
    int sel;
    int create_pct;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(99);
      create_pct = (sent < n_items / 2) ? 65 : 30;
      if (sel < 3) begin
        send_req(mk_req(FN_UNUSED, pick_key(), rand_size()));
      end else begin
        if (sel < create_pct)
          send_req(mk_req(FN_CREATE, pick_key(), rand_size()));
        else if (sel < 88)
          send_req(mk_req(FN_DELETE, pick_key(), rand_size()));
        else
          send_req(mk_req(FN_LIST, pick_key(), rand_size()));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    tbl_count = 0;
    err_count = 0;
    sender_idle_pct = 38;
    for (int i = 0; i < POOL_SIZE; i++) name_pool[i] = make_name($urandom_range(20));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_basic_ops();
    test_fill_and_drain();
    test_random_traffic(70, 38);
    test_random_traffic(70, 88);
    test_random_traffic(70, 0);
    start <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_rows.size() == 0) begin
      $display("named_entry_table_with_compaction_core_tb: PASS");
    end else begin
      $display("named_entry_table_with_compaction_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
design/netc_pkg.sv
design/netc_datapath.sv
design/netc_ctrl.sv
design/named_entry_table_with_compaction_core.sv
test/named_entry_table_with_compaction_core_tb.sv
